### design/sdaf_pkg.sv
// shared constants, types and helpers of the signed decimal formatter
package sdaf_pkg;

  localparam int DEFAULT_VALUE_BITS = 32;
  localparam int DP_W   = 4;
  localparam int CHAR_W = 8;
  localparam int BCD_W  = 4;

  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_POINT = 8'h2e;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2d;

  typedef struct packed {
    logic clr;
    logic dabble;
    logic shift;
  } cell_ctl_t;

  // decimal digits of the largest magnitude after saturation
  function automatic int num_digits(input int bits);
    longint m;
    int     n;
    m = (longint'(1) << (bits - 1)) - 1;
    n = 1;
    while (m >= 10) begin
      m = m / 10;
      n = n + 1;
    end
    return n;
  endfunction

endpackage

### design/sdaf_if.sv
// input and result channel interfaces of the formatter
interface sdaf_in_if #(
  parameter int VALUE_BITS = sdaf_pkg::DEFAULT_VALUE_BITS
);
  import sdaf_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [VALUE_BITS-1:0] value;
  logic [DP_W-1:0]       decimal_places;
  logic [CHAR_W-1:0]     separator;

  modport source (output valid, value, decimal_places, separator, input ready);
  modport sink   (input valid, value, decimal_places, separator, output ready);
endinterface

interface sdaf_out_if;
  import sdaf_pkg::*;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] character;
  logic              last;

  modport source (output valid, character, last, input ready);
  modport sink   (input valid, character, last, output ready);
endinterface

### design/sdaf_digit_cell.sv
// one bcd digit cell of the conversion and output shift chain
module sdaf_digit_cell (
  input  logic                       clk,
  input  sdaf_pkg::cell_ctl_t        ctl,
  input  logic                       bit_in,
  input  logic [sdaf_pkg::BCD_W-1:0] digit_in,
  output logic [sdaf_pkg::BCD_W-1:0] digit,
  output logic                       carry
);
  import sdaf_pkg::*;

  logic [BCD_W-1:0] digit_r;
  logic [BCD_W-1:0] digit_nxt;
  logic [BCD_W-1:0] adj;

  assign adj   = (digit_r >= 4'd5) ? digit_r + 4'd3 : digit_r;
  assign carry = adj[BCD_W-1];
  assign digit = digit_r;

  always_comb begin
    digit_nxt = digit_r;
    if (ctl.clr) begin
      digit_nxt = '0;
    end else if (ctl.dabble) begin
      digit_nxt = {adj[BCD_W-2:0], bit_in};
    end else if (ctl.shift) begin
      digit_nxt = digit_in;
    end
  end

  always_ff @(posedge clk) begin
    digit_r <= digit_nxt;
  end
endmodule

### design/signed_decimal_ascii_formatter_unit.sv
// top level: signed binary value to ascii decimal text with point and separator
//
//   channel | dir | payload                               | transfer
//   in_ch   | in  | value, decimal_places, separator      | valid && ready
//   out_ch  | out | character, last                       | valid && ready
//
// an item goes through its input transfer, double dabble of its VALUE_BITS-1
// magnitude bits in the digit chain and the dropping of leading zero digits,
// then one character per output transfer
// in_ch is ready only while no item is in work; out_ch stalls hold the chain
// reset clears the sequencer and the result register valid bit
module signed_decimal_ascii_formatter_unit #(
  parameter int VALUE_BITS = sdaf_pkg::DEFAULT_VALUE_BITS
) (
  input  logic         clk,
  input  logic         rst_n,
  sdaf_in_if.sink      in_ch,
  sdaf_out_if.source   out_ch
);
  import sdaf_pkg::*;

  localparam int NUM_DIGITS = num_digits(VALUE_BITS);
  localparam int MAG_W      = VALUE_BITS - 1;
  localparam int BIT_W      = (MAG_W > 1) ? $clog2(MAG_W) : 1;
  localparam int CNT_W      = $clog2(NUM_DIGITS + 1);
  localparam int CMP_W      = (CNT_W > DP_W) ? CNT_W : DP_W;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_CONV = 4'd1;
  localparam logic [3:0] ST_SKIP = 4'd2;
  localparam logic [3:0] ST_SIGN = 4'd3;
  localparam logic [3:0] ST_ZERO = 4'd4;
  localparam logic [3:0] ST_ZPT  = 4'd5;
  localparam logic [3:0] ST_DIG  = 4'd6;
  localparam logic [3:0] ST_PT   = 4'd7;
  localparam logic [3:0] ST_SEP  = 4'd8;

  logic [3:0]        state_r, state_nxt;
  logic [MAG_W-1:0]  mag_r, mag_nxt;
  logic [BIT_W-1:0]  bcnt_r, bcnt_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [DP_W-1:0]   dp_r, dp_nxt;
  logic [CHAR_W-1:0] sep_r, sep_nxt;
  logic              neg_r, neg_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0] out_char_r, out_char_nxt;
  logic              out_last_r, out_last_nxt;

  cell_ctl_t         ctl;
  logic [NUM_DIGITS:0]            link;
  logic [BCD_W-1:0]               digit_w [NUM_DIGITS];
  logic [BCD_W-1:0]               top_digit;

  logic              in_acc;
  logic              slot_free;
  logic              raw_neg;
  logic              raw_min;
  logic [VALUE_BITS-1:0] raw_neg_val;
  logic [CNT_W-1:0]  idx;
  logic [CMP_W-1:0]  cnt_ext, idx_ext, dp_ext;
  logic [3:0]        start_st;

  assign in_ch.ready   = (state_r == ST_IDLE);
  assign in_acc        = in_ch.valid && in_ch.ready;
  assign slot_free     = !out_valid_r || out_ch.ready;
  assign out_ch.valid     = out_valid_r;
  assign out_ch.character = out_char_r;
  assign out_ch.last      = out_last_r;

  assign raw_neg     = in_ch.value[VALUE_BITS-1];
  assign raw_min     = raw_neg && (in_ch.value[VALUE_BITS-2:0] == '0);
  assign raw_neg_val = ~in_ch.value + 1'b1;

  assign link[0]   = mag_r[MAG_W-1];
  assign top_digit = digit_w[NUM_DIGITS-1];

  for (genvar i = 0; i < NUM_DIGITS; i++) begin : g_cell
    logic [BCD_W-1:0] din;
    if (i == 0) begin : g_first
      assign din = '0;
    end else begin : g_next
      assign din = digit_w[i-1];
    end
    sdaf_digit_cell u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .bit_in   (link[i]),
      .digit_in (din),
      .digit    (digit_w[i]),
      .carry    (link[i+1])
    );
  end

  assign idx      = cnt_r - 1'b1;
  assign cnt_ext  = CMP_W'(cnt_r);
  assign idx_ext  = CMP_W'(idx);
  assign dp_ext   = CMP_W'(dp_r);
  assign start_st = neg_r ? ST_SIGN : ((cnt_ext == dp_ext) ? ST_ZERO : ST_DIG);

  always_comb begin
    state_nxt     = state_r;
    mag_nxt       = mag_r;
    bcnt_nxt      = bcnt_r;
    cnt_nxt       = cnt_r;
    dp_nxt        = dp_r;
    sep_nxt       = sep_r;
    neg_nxt       = neg_r;
    out_valid_nxt = out_ch.ready ? 1'b0 : out_valid_r;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    ctl           = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          ctl.clr  = 1'b1;
          dp_nxt   = in_ch.decimal_places;
          sep_nxt  = in_ch.separator;
          neg_nxt  = raw_neg;
          bcnt_nxt = BIT_W'(MAG_W - 1);
          if (raw_min) begin
            mag_nxt = '1;
          end else if (raw_neg) begin
            mag_nxt = raw_neg_val[MAG_W-1:0];
          end else begin
            mag_nxt = in_ch.value[MAG_W-1:0];
          end
          state_nxt = ST_CONV;
        end
      end
      ST_CONV: begin
        ctl.dabble = 1'b1;
        mag_nxt    = mag_r << 1;
        bcnt_nxt   = bcnt_r - 1'b1;
        if (bcnt_r == '0) begin
          cnt_nxt   = CNT_W'(NUM_DIGITS);
          state_nxt = ST_SKIP;
        end
      end
      ST_SKIP: begin
        if (top_digit == '0 && cnt_r != CNT_W'(1)) begin
          ctl.shift = 1'b1;
          cnt_nxt   = cnt_r - 1'b1;
        end else begin
          state_nxt = start_st;
        end
      end
      ST_SIGN: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = CH_MINUS;
          out_last_nxt  = 1'b0;
          state_nxt     = (cnt_ext == dp_ext) ? ST_ZERO : ST_DIG;
        end
      end
      ST_ZERO: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = CH_ZERO;
          out_last_nxt  = 1'b0;
          state_nxt     = ST_ZPT;
        end
      end
      ST_ZPT, ST_PT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = CH_POINT;
          out_last_nxt  = 1'b0;
          state_nxt     = ST_DIG;
        end
      end
      ST_DIG: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = CH_ZERO + CHAR_W'(top_digit);
          out_last_nxt  = 1'b0;
          ctl.shift     = 1'b1;
          cnt_nxt       = idx;
          if (idx == '0) begin
            out_last_nxt = (sep_r == '0);
            state_nxt    = (sep_r == '0) ? ST_IDLE : ST_SEP;
          end else if (idx_ext == dp_ext) begin
            state_nxt = ST_PT;
          end
        end
      end
      ST_SEP: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = sep_r;
          out_last_nxt  = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mag_r      <= mag_nxt;
    bcnt_r     <= bcnt_nxt;
    cnt_r      <= cnt_nxt;
    dp_r       <= dp_nxt;
    sep_r      <= sep_nxt;
    neg_r      <= neg_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end
endmodule

### design/sdaf_checker.sv
// port level checks of the formatter and their bind to the top level
module sdaf_checker #(
  parameter int VALUE_BITS = sdaf_pkg::DEFAULT_VALUE_BITS
) (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [sdaf_pkg::CHAR_W-1:0] out_character,
  input logic                        out_last
);
  import sdaf_pkg::*;

  logic in_acc;
  assign in_acc = in_valid && in_ready;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_character) && $stable(out_last))
    else $error("result changed under stall");

  // busy right after a transfer in
  a_busy_next: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_ready)
    else $error("ready right after input transfer");

  // input is still closed in the final conversion step; the steps before it are not checked
  a_busy_conv: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> ##(VALUE_BITS - 1) !in_ready)
    else $error("ready before conversion finished");

  // input reopens only with the final character in the result register
  a_reopen: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(in_ready) |-> out_valid && out_last)
    else $error("input reopened without final character");
endmodule

bind signed_decimal_ascii_formatter_unit sdaf_checker #(.VALUE_BITS(VALUE_BITS)) u_sdaf_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_character (out_ch.character),
  .out_last      (out_ch.last)
);
